/* rtl/imsf_pkg.sv */
package imsf_pkg;

  localparam int SENT_LEN  = 51;
  localparam int NCELL     = 49;
  localparam int IDX_W     = $clog2(SENT_LEN);
  localparam int CHAR_W    = 8;
  localparam int NUM_SAMP  = 6;
  localparam int SAMP_BASE = 7;
  localparam int DEC_BASE  = 37;

  localparam logic [IDX_W-1:0] SUM_FIRST = IDX_W'(1);
  localparam logic [IDX_W-1:0] SUM_LAST  = IDX_W'(48);
  localparam logic [IDX_W-1:0] IDX_CK_HI = IDX_W'(49);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SENT_LEN - 1);

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_G      = 8'h47;
  localparam logic [CHAR_W-1:0] CH_P      = 8'h50;
  localparam logic [CHAR_W-1:0] CH_I      = 8'h49;
  localparam logic [CHAR_W-1:0] CH_M      = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_U      = 8'h55;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_HEXA   = 8'h37;  // 'A' - 10

  typedef logic [NCELL-1:0][CHAR_W-1:0] cells_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic [3:0] q;
    logic [6:0] r;
  } dec_split_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib <= 4'd9) begin
      c = CH_ZERO + {4'b0, nib};
    end else begin
      c = CH_HEXA + {4'b0, nib};
    end
    return c;
  endfunction

  // Split a value below 1000 into hundreds digit and remainder.
  function automatic dec_split_t split100(input logic [9:0] v);
    dec_split_t res;
    logic [9:0] rem;
    res.q = 4'd0;
    rem   = v;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 10'(k * 100)) begin
        res.q = 4'(k);
        rem   = v - 10'(k * 100);
      end
    end
    res.r = rem[6:0];
    return res;
  endfunction

  // Split a value below 100 into tens digit and units.
  function automatic dec_split_t split10(input logic [6:0] v);
    dec_split_t res;
    logic [6:0] rem;
    res.q = 4'd0;
    rem   = v;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 7'(k * 10)) begin
        res.q = 4'(k);
        rem   = v - 7'(k * 10);
      end
    end
    res.r = rem;
    return res;
  endfunction

endpackage

/* rtl/imsf_cell.sv */
module imsf_cell (
  input  logic                         clk,
  input  imsf_pkg::cell_ctl_t          ctl,
  input  logic [imsf_pkg::CHAR_W-1:0]  load_byte,
  input  logic [imsf_pkg::CHAR_W-1:0]  right_byte,
  output logic [imsf_pkg::CHAR_W-1:0]  byte_q
);
  import imsf_pkg::*;

  logic [CHAR_W-1:0] byte_r;
  logic [CHAR_W-1:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.load) begin
      byte_nxt = load_byte;
    end else if (ctl.shift) begin
      byte_nxt = right_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q = byte_r;

endmodule

/* rtl/imsf_build.sv */
module imsf_build (
  input  logic [15:0]      accel_x,
  input  logic [15:0]      accel_y,
  input  logic [15:0]      accel_z,
  input  logic [15:0]      gyro_x,
  input  logic [15:0]      gyro_y,
  input  logic [15:0]      gyro_z,
  input  logic [4:0]       hours,
  input  logic [5:0]       minutes,
  input  logic [5:0]       seconds,
  input  logic [7:0]       subsecond_count,
  output imsf_pkg::cells_t load_bytes
);
  import imsf_pkg::*;

  logic [NUM_SAMP-1:0][15:0] samp;
  logic [7:0]                ss_down;
  logic [17:0]               ms_prod;
  logic [9:0]                ms;
  dec_split_t                ms_h;
  dec_split_t                ms_t;
  dec_split_t                hh;
  dec_split_t                mm;
  dec_split_t                sc;

  assign samp = {gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x};

  // milliseconds = (255 - count) * 1000 / 256, at most 996
  assign ss_down = 8'd255 - subsecond_count;
  assign ms_prod = {10'b0, ss_down} * 18'd1000;
  assign ms      = ms_prod[17:8];
  assign ms_h    = split100(ms);
  assign ms_t    = split10(ms_h.r);
  assign hh      = split10({2'b0, hours});
  assign mm      = split10({1'b0, minutes});
  assign sc      = split10({1'b0, seconds});

  always_comb begin
    load_bytes[0] = CH_DOLLAR;
    load_bytes[1] = CH_G;
    load_bytes[2] = CH_P;
    load_bytes[3] = CH_I;
    load_bytes[4] = CH_M;
    load_bytes[5] = CH_U;
    load_bytes[6] = CH_COMMA;
    for (int k = 0; k < NUM_SAMP; k++) begin
      for (int j = 0; j < 4; j++) begin
        load_bytes[SAMP_BASE + 5*k + j] = hex_char(samp[k][15 - 4*j -: 4]);
      end
      load_bytes[SAMP_BASE + 5*k + 4] = CH_COMMA;
    end
    load_bytes[DEC_BASE]      = CH_ZERO + {4'b0, hh.q};
    load_bytes[DEC_BASE + 1]  = CH_ZERO + {1'b0, hh.r};
    load_bytes[DEC_BASE + 2]  = CH_ZERO + {4'b0, mm.q};
    load_bytes[DEC_BASE + 3]  = CH_ZERO + {1'b0, mm.r};
    load_bytes[DEC_BASE + 4]  = CH_ZERO + {4'b0, sc.q};
    load_bytes[DEC_BASE + 5]  = CH_ZERO + {1'b0, sc.r};
    load_bytes[DEC_BASE + 6]  = CH_DOT;
    load_bytes[DEC_BASE + 7]  = CH_ZERO + {7'b0, (ms >= 10'd1000)};
    load_bytes[DEC_BASE + 8]  = CH_ZERO + {4'b0, ms_h.q};
    load_bytes[DEC_BASE + 9]  = CH_ZERO + {4'b0, ms_t.q};
    load_bytes[DEC_BASE + 10] = CH_ZERO + {1'b0, ms_t.r};
    load_bytes[DEC_BASE + 11] = CH_STAR;
  end

endmodule

/* rtl/imu_sentence_formatter.sv */
// Formats one set of six 16-bit motion samples and a time of day into a
// 51-byte ASCII sentence "$GPIMU,XXXX,...,hhmmss.mmmm*CC" and streams it
// out one byte per clock on out_char_out, marked by out_valid, with
// out_last_char high on the final checksum digit. A transaction is taken
// when start is high and busy is low; the byte cells load on acceptance,
// the first byte then passes through the output register, and the 51
// bytes follow back to back. The receiver cannot stall: every byte is
// shown for exactly one cycle. busy drops in the cycle that forms the
// final byte, so a new start can be taken there and the next sentence
// follows with no gap. The sentence rate is set by the one-byte-per-cycle
// output port: the first 49 bytes sit in a row of byte cells that shift
// toward the output each cycle, and the XOR checksum is gathered as those
// bytes leave and then sent as two hex digits.
module imu_sentence_formatter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [15:0]                  in_accel_x,
  input  logic [15:0]                  in_accel_y,
  input  logic [15:0]                  in_accel_z,
  input  logic [15:0]                  in_gyro_x,
  input  logic [15:0]                  in_gyro_y,
  input  logic [15:0]                  in_gyro_z,
  input  logic [4:0]                   in_hours,
  input  logic [5:0]                   in_minutes,
  input  logic [5:0]                   in_seconds,
  input  logic [7:0]                   in_subsecond_count,
  output logic                         out_valid,
  output logic [imsf_pkg::CHAR_W-1:0]  out_char_out,
  output logic                         out_last_char
);
  import imsf_pkg::*;

  logic              accept;
  cells_t            load_bytes;
  cells_t            cell_q;
  cell_ctl_t         ctl;

  logic              active_r,    active_nxt;
  logic [IDX_W-1:0]  idx_r,       idx_nxt;
  logic [CHAR_W-1:0] acc_r,       acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r,  out_char_nxt;
  logic              out_last_r,  out_last_nxt;

  // Stay busy until the cycle that forms the final byte.
  assign busy   = active_r && (idx_r != IDX_LAST);
  assign accept = start && !busy;

  imsf_build u_build (
    .accel_x         (in_accel_x),
    .accel_y         (in_accel_y),
    .accel_z         (in_accel_z),
    .gyro_x          (in_gyro_x),
    .gyro_y          (in_gyro_y),
    .gyro_z          (in_gyro_z),
    .hours           (in_hours),
    .minutes         (in_minutes),
    .seconds         (in_seconds),
    .subsecond_count (in_subsecond_count),
    .load_bytes      (load_bytes)
  );

  // Load the whole row on a new transaction; advance one byte toward
  // cell 0 while the body of the sentence is still leaving.
  assign ctl.load  = accept;
  assign ctl.shift = active_r && (idx_r <= SUM_LAST);

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    logic [CHAR_W-1:0] right;
    if (g == NCELL - 1) begin : g_tail
      assign right = CH_NUL;
    end else begin : g_mid
      assign right = cell_q[g+1];
    end
    imsf_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load_byte  (load_bytes[g]),
      .right_byte (right),
      .byte_q     (cell_q[g])
    );
  end

  // Sequencing: index of the byte formed this cycle.
  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (accept) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
    end else if (active_r) begin
      if (idx_r == IDX_LAST) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  // Checksum: fold in bytes after '$' up to and including '*'.
  always_comb begin
    acc_nxt = acc_r;
    if (accept) begin
      acc_nxt = '0;
    end else if (active_r && (idx_r >= SUM_FIRST) && (idx_r <= SUM_LAST)) begin
      acc_nxt = acc_r ^ cell_q[0];
    end
  end

  // Output byte: drain the cell row, then the two checksum digits.
  always_comb begin
    out_valid_nxt = active_r;
    out_last_nxt  = active_r && (idx_r == IDX_LAST);
    if (idx_r <= SUM_LAST) begin
      out_char_nxt = cell_q[0];
    end else if (idx_r == IDX_CK_HI) begin
      out_char_nxt = hex_char(acc_r[7:4]);
    end else begin
      out_char_nxt = hex_char(acc_r[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_out  = out_char_r;
  assign out_last_char = out_last_r;

`ifndef SYNTH
  // Every accepted transaction opens with '$', shown once it has passed
  // through the cell row and the output register.
  a_first_dollar: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 (out_valid && (out_char_out == CH_DOLLAR)))
    else $error("sentence did not open with dollar sign");

  // The final byte is always preceded by a valid byte.
  a_last_contig: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_char) |-> $past(out_valid))
    else $error("final byte without preceding byte");

  // Nothing is emitted while the sequencer is idle.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!active_r && !accept) |=> !out_valid)
    else $error("byte emitted while idle");
`endif

endmodule
